/* src/vdgpg_pkg.sv */
// Shared types, codes and constants of the VDG pixel generator.
// No dependencies; every other file of the block imports this package.
package vdgpg_pkg;

    // Input operation codes.
    localparam logic [1:0] OP_DATA   = 2'd0;
    localparam logic [1:0] OP_BORDER = 2'd1;
    localparam logic [1:0] OP_EOL    = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_VDG_MODE      = 2'd0;
    localparam logic [1:0] CFG_LINE_FORMAT   = 2'd1;
    localparam logic [1:0] CFG_ARTIFACT_MODE = 2'd2;

    // Line formats; six and seven render like rg6.
    localparam logic [2:0] LF_SG4 = 3'd0;
    localparam logic [2:0] LF_SG6 = 3'd1;
    localparam logic [2:0] LF_CG1 = 3'd2;
    localparam logic [2:0] LF_RG1 = 3'd3;
    localparam logic [2:0] LF_CG2 = 3'd4;

    // Colour codes outside the 16-entry palette.
    localparam logic [4:0] COL_BLACK   = 5'd16;
    localparam logic [4:0] COL_DKGREEN = 5'd17;

    // Last character row before the row counter wraps.
    localparam logic [3:0] LAST_ROW = 4'd11;

    typedef logic [4:0] t_pix;
    typedef logic [7:0][4:0] t_pix8;

    typedef struct packed {
        logic [7:0] vdg_mode;
        logic [2:0] line_format;
        logic [1:0] artifact_mode;
    } t_cfg;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
        logic [7:0] font_row;
        logic [3:0] row;
    } t_item;

    typedef struct packed {
        logic             two;
        logic [15:0][4:0] px;
    } t_result;

    typedef struct packed {
        logic valid;
        logic phase;
        logic two;
        logic free;
    } t_out_stat;

endpackage

/* src/video_display_pixel_generator_unit.sv */
// Top level of the VDG pixel generator: input register, decode, result register.
// Depends on vdgpg_pkg, vdgpg_regs, vdgpg_decode and vdgpg_out.
//
// The block turns video memory bytes into 5-bit colour codes, eight pixels to
// a result (codes 0 to 15 are palette entries, 16 is black, 17 dark green).
// An accepted item is held in an input register together with the character
// row it belongs to, decoded by shallow logic and written to a result
// register. The block takes one item per cycle as long as results are taken.
// A data byte in the cg1 or rg1 format gives two results and holds the single
// result register until both have been taken; the next item waits in the
// input register meanwhile. Border groups give one result of border colour.
// An end of line gives no result and advances the 0 to 11 row counter at the
// moment it is accepted; operation code three is dropped. Configuration
// writes are always ready and should be made only while no item is in flight.
module video_display_pixel_generator_unit
    import vdgpg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_op,
    input  logic [7:0] i_data_byte,
    input  logic [7:0] i_font_row,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [4:0] o_pix_a,
    output logic [4:0] o_pix_b,
    output logic [4:0] o_pix_c,
    output logic [4:0] o_pix_d,
    output logic [4:0] o_pix_e,
    output logic [4:0] o_pix_f,
    output logic [4:0] o_pix_g,
    output logic [4:0] o_pix_h,
    output logic       o_last_of_run,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_cfg      cfg;
    logic [3:0] row;
    t_item     r_in;
    logic      r_in_valid;
    logic      n_in_valid;
    logic      accept;
    logic      keep;
    logic      in_move;
    t_result   res;
    t_pix8     pix;
    t_out_stat out_stat;

    assign o_cfg_ready = 1'b1;

    // The input register moves on whenever the result register can take it.
    assign in_move = r_in_valid && out_stat.free;
    assign o_stall = r_in_valid && !out_stat.free;
    assign accept  = i_valid && !o_stall;
    // Only data bytes and border groups produce results and occupy the stage.
    assign keep    = accept && (i_op == OP_DATA || i_op == OP_BORDER);

    vdgpg_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_row_adv   (accept && i_op == OP_EOL),
        .o_cfg       (cfg),
        .o_row       (row)
    );

    always_comb begin
        if (keep) begin
            n_in_valid = 1'b1;
        end else if (in_move) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // The row is captured with the item, so a later end of line cannot
    // affect a byte that is still waiting.
    always_ff @(posedge i_clk) begin
        if (keep) begin
            r_in.op        <= i_op;
            r_in.data_byte <= i_data_byte;
            r_in.font_row  <= i_font_row;
            r_in.row       <= row;
        end
    end

    vdgpg_decode u_decode (
        .i_cfg  (cfg),
        .i_item (r_in),
        .o_res  (res)
    );

    vdgpg_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_move),
        .i_res   (res),
        .i_stall (i_stall),
        .o_pix   (pix),
        .o_valid (o_valid),
        .o_last  (o_last_of_run),
        .o_stat  (out_stat)
    );

    assign o_pix_a = pix[0];
    assign o_pix_b = pix[1];
    assign o_pix_c = pix[2];
    assign o_pix_d = pix[3];
    assign o_pix_e = pix[4];
    assign o_pix_f = pix[5];
    assign o_pix_g = pix[6];
    assign o_pix_h = pix[7];

`ifndef SYNTHESIS
    // Upstream is held off only while an item waits in the input register.
    a_stall_holds_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid)
        else $error("stall raised with no item held");

    // A first half that is taken is followed by the last half of the item.
    a_second_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_of_run |=> o_valid && o_last_of_run)
        else $error("second result of a two-result item missing");

    // The second half is only shown for an item that has two results.
    a_phase_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_stat.valid && out_stat.phase |-> out_stat.two)
        else $error("second half shown for a single-result item");

    // An accepted end of line steps the row counter, wrapping after row eleven.
    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_op == OP_EOL |=>
            row == (($past(row) >= LAST_ROW) ? 4'd0 : $past(row) + 4'd1))
        else $error("row counter did not advance correctly");
`endif

endmodule

/* src/vdgpg_regs.sv */
// Configuration registers and the character row counter.
// Depends on vdgpg_pkg.
module vdgpg_regs
    import vdgpg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_row_adv,
    output t_cfg       o_cfg,
    output logic [3:0] o_row
);

    t_cfg       r_cfg;
    logic [3:0] r_row;
    logic [3:0] n_row;

    assign n_row = (r_row >= LAST_ROW) ? 4'd0 : r_row + 4'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
            r_row <= 4'd0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_VDG_MODE:      r_cfg.vdg_mode      <= i_cfg_data;
                    CFG_LINE_FORMAT:   r_cfg.line_format   <= i_cfg_data[2:0];
                    CFG_ARTIFACT_MODE: r_cfg.artifact_mode <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_row_adv) begin
                r_row <= n_row;
            end
        end
    end

    assign o_cfg = r_cfg;
    assign o_row = r_row;

endmodule

/* src/vdgpg_decode.sv */
// Combinational colour selection and pixel decode of one registered item.
// Depends on vdgpg_pkg.
module vdgpg_decode
    import vdgpg_pkg::*;
(
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    output t_result o_res
);

    logic       css;
    logic [1:0] art;
    t_pix       fg;
    t_pix       bg;
    t_pix       border;
    t_pix       cg;
    logic [7:0] b;
    logic [7:0] pat;
    logic [2:0] hi;
    t_pix       c;
    t_result    res;

    assign css = i_cfg.vdg_mode[3];
    assign art = (i_cfg.artifact_mode == 2'd3) ? 2'd2 : i_cfg.artifact_mode;
    assign b   = i_item.data_byte;

    // Colour set, foreground, background and border from the mode byte.
    always_comb begin
        if (i_cfg.vdg_mode[7]) begin
            if (i_cfg.vdg_mode[6:4] == 3'b111 && art != 2'd0) begin
                cg = 5'd4 + {1'b0, art, 2'b00};
            end else begin
                cg = {2'b00, css, 2'b00};
            end
            fg     = {2'b00, css, 2'b00};
            bg     = COL_BLACK;
            border = fg;
        end else begin
            bg     = COL_DKGREEN;
            border = COL_BLACK;
            fg     = css ? 5'd7 : 5'd0;
            cg     = {2'b00, css, 2'b00};
        end
    end

    always_comb begin
        res    = '0;
        pat    = 8'd0;
        hi     = 3'd1;
        c      = 5'd0;
        if (i_item.op == OP_BORDER) begin
            for (int i = 0; i < 8; i++) begin
                res.px[i] = border;
            end
        end else begin
            unique case (i_cfg.line_format)
                LF_SG4: begin
                    if (b[7]) begin
                        // Semigraphics 4: upper half of the cell lights bits 3/2.
                        c  = {2'b00, b[6:4]};
                        hi = (i_item.row < 4'd6) ? 3'd3 : 3'd1;
                        for (int i = 0; i < 4; i++) begin
                            res.px[i]     = b[hi] ? c : COL_BLACK;
                            res.px[i + 4] = b[hi - 3'd1] ? c : COL_BLACK;
                        end
                    end else begin
                        pat = b[6] ? ~i_item.font_row : i_item.font_row;
                        for (int i = 0; i < 8; i++) begin
                            res.px[i] = pat[7 - i] ? fg : bg;
                        end
                    end
                end
                LF_SG6: begin
                    if (b[7]) begin
                        c  = cg + {3'b000, b[7:6]};
                        hi = (i_item.row < 4'd4) ? 3'd5 :
                             ((i_item.row < 4'd8) ? 3'd3 : 3'd1);
                        for (int i = 0; i < 4; i++) begin
                            res.px[i]     = b[hi] ? c : COL_BLACK;
                            res.px[i + 4] = b[hi - 3'd1] ? c : COL_BLACK;
                        end
                    end else begin
                        // External alpha: the byte is its own pattern.
                        pat = b[6] ? ~b : b;
                        for (int i = 0; i < 8; i++) begin
                            res.px[i] = pat[7 - i] ? fg : bg;
                        end
                        res.px[1] = bg;
                    end
                end
                LF_CG1: begin
                    for (int i = 0; i < 16; i++) begin
                        res.px[i] = cg + {3'b000, b[6 - 2 * (i / 4) +: 2]};
                    end
                    res.two = 1'b1;
                end
                LF_RG1: begin
                    for (int i = 0; i < 16; i++) begin
                        res.px[i] = b[7 - (i / 2)] ? fg : bg;
                    end
                    res.two = 1'b1;
                end
                LF_CG2: begin
                    for (int i = 0; i < 8; i++) begin
                        res.px[i] = cg + {3'b000, b[6 - 2 * (i / 2) +: 2]};
                    end
                end
                default: begin
                    for (int i = 0; i < 8; i++) begin
                        res.px[i] = b[7 - i] ? fg : bg;
                    end
                end
            endcase
        end
    end

    assign o_res = res;

endmodule

/* src/vdgpg_out.sv */
// Result register: holds one decoded item and hands it out as one or two
// 8-pixel results. Depends on vdgpg_pkg.
module vdgpg_out
    import vdgpg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_result   i_res,
    input  logic      i_stall,
    output t_pix8     o_pix,
    output logic      o_valid,
    output logic      o_last,
    output t_out_stat o_stat
);

    t_result r_res;
    logic    r_valid;
    logic    r_phase;
    logic    last;

    assign last = !r_res.two || r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_phase <= 1'b0;
        end else if (r_valid && !i_stall) begin
            if (last) begin
                r_valid <= 1'b0;
                r_phase <= 1'b0;
            end else begin
                r_phase <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_pix   = r_phase ? r_res.px[15:8] : r_res.px[7:0];
    assign o_valid = r_valid;
    assign o_last  = last;

    assign o_stat.valid = r_valid;
    assign o_stat.phase = r_phase;
    assign o_stat.two   = r_res.two;
    assign o_stat.free  = !r_valid || (!i_stall && last);

endmodule

/* tb/tb_video_display_pixel_generator_unit.sv */
// Self-checking bench for video_display_pixel_generator_unit: directed and random items,
// register writes between phases, and a colour predictor built into the bench.
// Depends on vdgpg_pkg and the RTL of the block; reads no files.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vdgpg_pkg::*;

    // Register slot three exists on the index bus but holds nothing; writes to it are
    // dropped by the block.
    localparam logic [1:0] CFG_SPARE = 2'd3;

    // An item passes the input register and the result register on its way out; the
    // settle time lets anything still inside the pipe come out.
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_LIMIT     = 200000;
    localparam int ITEMS_PER_SWEEP = 500;
    localparam int CONFIG_SPAN     = 100;
    localparam int MAX_REPORTS     = 10;

    // One result of the block: eight pixel codes plus the end-of-item flag.
    // pix[0] is the left-most pixel, which the block puts on o_pix_a.
    typedef struct packed {
        t_pix8 pix;
        logic  last;
    } t_pixel_group;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [1:0] i_op = OP_DATA;
    logic [7:0] i_data_byte = 8'h00;
    logic [7:0] i_font_row = 8'h00;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [4:0] o_pix_a, o_pix_b, o_pix_c, o_pix_d;
    logic [4:0] o_pix_e, o_pix_f, o_pix_g, o_pix_h;
    logic       o_last_of_run;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = CFG_VDG_MODE;
    logic [7:0] i_cfg_data = 8'h00;

    // The bench's own copy of the block's registers and character row counter.
    logic [7:0] vdg_mode_reg    = 8'h00;
    logic [2:0] line_format_reg = LF_SG4;
    logic [1:0] artifact_reg    = 2'd0;
    logic [3:0] char_row        = 4'd0;

    // Pixel groups predicted but not yet seen on the output, oldest first.
    t_pixel_group pixel_groups_due[$];

    // Percent of cycles in which the sender holds back and the receiver stalls.
    int snd_idle_pct  = 36;
    int rcv_stall_pct = 64;

    int items_accepted = 0;
    int groups_checked = 0;
    int settings_used  = 0;
    int failures       = 0;

    video_display_pixel_generator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_data_byte   (i_data_byte),
        .i_font_row    (i_font_row),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pix_a       (o_pix_a),
        .o_pix_b       (o_pix_b),
        .o_pix_c       (o_pix_c),
        .o_pix_d       (o_pix_d),
        .o_pix_e       (o_pix_e),
        .o_pix_f       (o_pix_f),
        .o_pix_g       (o_pix_g),
        .o_pix_h       (o_pix_h),
        .o_last_of_run (o_last_of_run),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block stops handing out items or results altogether.
    initial begin
        #2_000_000;
        $display("video_display_pixel_generator_unit regression: fail");
        $finish;
    end

    // Only the first few failures are printed in full; the rest are just counted.
    function automatic void note_failure(input string what);
        if (failures < MAX_REPORTS)
            $display("ERROR at %0t ns: %s", $time, what);
        failures++;
    endfunction

    // Works out the pixel groups that one accepted item produces under the current
    // register settings and queues them. An end of line only moves the character row on.
    function automatic void paint_item(input logic [1:0] op, input logic [7:0] b,
                                       input logic [7:0] fr);
        t_pix         fg, bg, border, cg, c;
        t_pix         px[16];
        logic [7:0]   pat;
        logic [1:0]   art;
        int           hi;
        int           groups;
        t_pixel_group grp;

        groups = 1;
        // Artifact setting three behaves like two.
        art = (artifact_reg == 2'd3) ? 2'd2 : artifact_reg;

        if (vdg_mode_reg[7]) begin
            // Graphics: in the highest mode with artifacts on, the colour set moves
            // up while foreground and border keep the plain colour set base.
            if (vdg_mode_reg[6:4] == 3'b111 && art != 2'd0) begin
                cg = 5'd4 + {1'b0, art, 2'b00};
                fg = {2'b00, vdg_mode_reg[3], 2'b00};
            end else begin
                cg = {2'b00, vdg_mode_reg[3], 2'b00};
                fg = cg;
            end
            bg     = COL_BLACK;
            border = fg;
        end else begin
            cg     = {2'b00, vdg_mode_reg[3], 2'b00};
            fg     = vdg_mode_reg[3] ? 5'd7 : 5'd0;
            bg     = COL_DKGREEN;
            border = COL_BLACK;
        end

        case (op)
            OP_EOL: begin
                char_row = (char_row >= LAST_ROW) ? 4'd0 : char_row + 4'd1;
                return;
            end
            OP_NONE: return;
            OP_BORDER: begin
                foreach (px[i])
                    px[i] = border;
            end
            default: begin
                case (line_format_reg)
                    LF_SG4: begin
                        if (b[7]) begin
                            // Semigraphics 4: the top half of the cell uses bits 3..2.
                            c  = {2'b00, b[6:4]};
                            hi = (char_row < 4'd6) ? 3 : 1;
                            for (int i = 0; i < 4; i++) begin
                                px[i]     = b[hi] ? c : COL_BLACK;
                                px[i + 4] = b[hi - 1] ? c : COL_BLACK;
                            end
                        end else begin
                            pat = b[6] ? ~fr : fr;
                            for (int i = 0; i < 8; i++)
                                px[i] = pat[7 - i] ? fg : bg;
                        end
                    end
                    LF_SG6: begin
                        if (b[7]) begin
                            // Semigraphics 6: three bands of four rows each.
                            c  = cg + {3'b000, b[7:6]};
                            hi = (char_row < 4'd4) ? 5 : ((char_row < 4'd8) ? 3 : 1);
                            for (int i = 0; i < 4; i++) begin
                                px[i]     = b[hi] ? c : COL_BLACK;
                                px[i + 4] = b[hi - 1] ? c : COL_BLACK;
                            end
                        end else begin
                            // External alpha: the byte is its own pattern and the
                            // second pixel is always background.
                            pat = b[6] ? ~b : b;
                            for (int i = 0; i < 8; i++)
                                px[i] = pat[7 - i] ? fg : bg;
                            px[1] = bg;
                        end
                    end
                    LF_CG1: begin
                        for (int i = 0; i < 16; i++)
                            px[i] = cg + {3'b000, b[6 - 2 * (i / 4) +: 2]};
                        groups = 2;
                    end
                    LF_RG1: begin
                        for (int i = 0; i < 16; i++)
                            px[i] = b[7 - i / 2] ? fg : bg;
                        groups = 2;
                    end
                    LF_CG2: begin
                        for (int i = 0; i < 8; i++)
                            px[i] = cg + {3'b000, b[6 - 2 * (i / 2) +: 2]};
                    end
                    default: begin
                        // rg6, and the two unused format codes that alias it.
                        for (int i = 0; i < 8; i++)
                            px[i] = b[7 - i] ? fg : bg;
                    end
                endcase
            end
        endcase

        for (int g = 0; g < groups; g++) begin
            for (int j = 0; j < 8; j++)
                grp.pix[j] = px[g * 8 + j];
            grp.last = (g == groups - 1);
            pixel_groups_due.push_back(grp);
        end
    endfunction

    // Result side: compare every accepted result with the oldest prediction, then pick
    // the stall for the next cycle. Values read here are the ones from before the edge.
    always @(posedge i_clk) begin : check_results
        t_pixel_group seen;
        t_pixel_group want;

        if (i_rst_n && o_valid && !i_stall) begin
            seen.pix  = {o_pix_h, o_pix_g, o_pix_f, o_pix_e,
                         o_pix_d, o_pix_c, o_pix_b, o_pix_a};
            seen.last = o_last_of_run;
            if (pixel_groups_due.size() == 0) begin
                note_failure($sformatf("unexpected result %p", seen));
            end else begin
                want = pixel_groups_due.pop_front();
                groups_checked++;
                for (int j = 0; j < 8; j++)
                    if (seen.pix[j] !== want.pix[j])
                        note_failure($sformatf("o_pix_%c: expected %0d, got %0d",
                                               "a" + j, want.pix[j], seen.pix[j]));
                if (seen.last !== want.last)
                    note_failure($sformatf("o_last_of_run: expected %0b, got %0b",
                                           want.last, seen.last));
            end
        end
        i_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    // Offers one item, holding it steady until the block takes it, and predicts its
    // results at the edge where it is accepted.
    task automatic send_item(input logic [1:0] op, input logic [7:0] b, input logic [7:0] fr);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_op        <= op;
        i_data_byte <= b;
        i_font_row  <= fr;
        do @(posedge i_clk); while (o_stall);
        paint_item(op, b, fr);
        if (op != OP_NONE)
            items_accepted++;
    endtask

    // Stops offering items until every predicted result has come out, then lets the
    // given number of cycles pass so that items without results also leave the pipe.
    task automatic hold_until_drained(input int settle);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pixel_groups_due.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Writes all registers, plus the empty slot, back to back once the block is idle.
    task automatic write_registers(input logic [7:0] mode, input logic [7:0] fmt_raw,
                                   input logic [7:0] art_raw);
        logic [1:0] idx[4];
        logic [7:0] val[4];

        idx = '{CFG_VDG_MODE, CFG_LINE_FORMAT, CFG_ARTIFACT_MODE, CFG_SPARE};
        val = '{mode, fmt_raw, art_raw, 8'($urandom)};
        hold_until_drained(SETTLE_CYCLES);
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx[k])
                CFG_VDG_MODE:      vdg_mode_reg    = val[k];
                CFG_LINE_FORMAT:   line_format_reg = val[k][2:0];
                CFG_ARTIFACT_MODE: artifact_reg    = val[k][1:0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
        @(posedge i_clk);
    endtask

    // Reset values: alpha text on a dark green background, every operation once,
    // including the unused code that the block must drop.
    task automatic test_reset_state();
        send_item(OP_DATA, 8'h00, 8'h00);
        send_item(OP_DATA, 8'h3f, 8'hff);
        send_item(OP_DATA, 8'h40, 8'h81);
        send_item(OP_BORDER, 8'hff, 8'hff);
        send_item(OP_NONE, 8'hff, 8'hff);
        send_item(OP_EOL, 8'h00, 8'h00);
        send_item(OP_DATA, 8'hff, 8'h00);
    endtask

    // Every line format code once, the two aliases of rg6 among them, with a
    // semigraphics byte and an inverted text byte each. The graphics runs use the
    // highest mode so the artifact colour set, saturated setting included, comes in.
    task automatic test_each_format();
        logic [7:0] mode;
        logic [7:0] art;

        for (int f = 0; f < 8; f++) begin
            if (f < 2) begin
                mode = (f == 0) ? 8'h00 : 8'h08;
                art  = 8'h00;
            end else begin
                mode = (f % 2 == 1) ? 8'hf8 : 8'hf0;
                art  = (f == 7) ? 8'h03 : ((f == 2) ? 8'h02 : ((f == 5) ? 8'h01 : 8'h00));
            end
            write_registers(mode, 8'(f), art);
            send_item(OP_DATA, 8'hff, 8'h00);
            send_item(OP_DATA, 8'h4b, 8'ha5);
        end
    endtask

    // Random traffic shaped as display lines: a run of bytes with the odd border group
    // and stray codes, closed by an end of line so the row counter walks through all
    // twelve rows. Registers change every hundred items or so, starting each sweep with
    // all register bits set and then all clear.
    task automatic test_random_traffic(input int snd_pct, input int rcv_pct);
        int         sent;
        int         since_cfg;
        int         lines;
        int         picks;
        int         r;
        logic [7:0] mode;

        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
        sent      = 0;
        since_cfg = CONFIG_SPAN;
        lines     = 0;
        picks     = 0;
        while (sent < ITEMS_PER_SWEEP) begin
            if (since_cfg >= CONFIG_SPAN) begin
                if (picks == 0) begin
                    write_registers(8'hff, 8'hff, 8'hff);
                end else if (picks == 1) begin
                    write_registers(8'h00, 8'h00, 8'h00);
                end else begin
                    mode = 8'($urandom);
                    // Lean toward the highest graphics mode, where artifacts matter.
                    if ($urandom_range(3) == 0)
                        mode[7:4] = 4'hf;
                    write_registers(mode, 8'($urandom), 8'($urandom));
                end
                picks++;
                since_cfg = 0;
            end
            repeat ($urandom_range(1, 20)) begin
                r = $urandom_range(99);
                if (r < 85)
                    send_item(OP_DATA, 8'($urandom), 8'($urandom));
                else if (r < 94)
                    send_item(OP_BORDER, 8'($urandom), 8'($urandom));
                else if (r < 97)
                    send_item(OP_NONE, 8'($urandom), 8'($urandom));
                else
                    send_item(OP_EOL, 8'($urandom), 8'($urandom));
                if (r < 94 || r >= 97) begin
                    sent++;
                    since_cfg++;
                end
            end
            send_item(OP_EOL, 8'($urandom), 8'($urandom));
            sent++;
            since_cfg++;
            lines++;
            // Now and then the sender waits for the output to run completely dry.
            if (lines % 25 == 7)
                hold_until_drained(0);
        end
    endtask

    initial begin : main_sequence
        int waited;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_each_format();
        test_random_traffic(36, 64);
        test_random_traffic(64, 36);
        test_random_traffic(0, 0);

        // All items are in; wait for the remaining results, then watch a little longer
        // for anything the block should not have produced.
        i_valid <= 1'b0;
        waited = 0;
        while (pixel_groups_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pixel_groups_due.size() != 0)
            note_failure($sformatf("%0d predicted results never arrived",
                                   pixel_groups_due.size()));

        $display("Covered %0d items and %0d pixel groups under %0d register settings,",
                 items_accepted, groups_checked, settings_used);
        $display("all line formats in text, semigraphics and graphics modes; %0d failures.",
                 failures);
        if (failures == 0)
            $display("video_display_pixel_generator_unit regression: pass");
        else
            $display("video_display_pixel_generator_unit regression: fail");
        $finish;
    end

endmodule
